// ===== design/mip_level_box_downsampler_top_macros.svh =====
// ----------------------------------------------------------------------------
// mip level box downsampler assertion macros
// shared concurrent check forms for the downsampler rtl
// ----------------------------------------------------------------------------
`ifndef MIP_LEVEL_BOX_DOWNSAMPLER_TOP_MACROS_SVH
`define MIP_LEVEL_BOX_DOWNSAMPLER_TOP_MACROS_SVH

// same-cycle implication
`define MLBD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mlbd: same-cycle check failed");

// next-cycle implication
`define MLBD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mlbd: next-cycle check failed");

`endif

// ===== design/mlbd_pkg.sv =====
// ----------------------------------------------------------------------------
// mlbd_pkg
// types, register codes and the srgb-to-linear table of the mip downsampler
// ----------------------------------------------------------------------------
package mlbd_pkg;

  localparam int unsigned PORT_CH    = 4;
  localparam int unsigned CODE_W     = 16;
  localparam int unsigned HSUM_W     = 17;
  localparam int unsigned TOTAL_W    = 18;
  localparam int unsigned SRGB_W     = 8;
  localparam int unsigned LIN_DEPTH  = 256;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned FW_W       = 13;
  localparam int unsigned FH_W       = 16;
  localparam int unsigned NCH_W      = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FINE_WIDTH    = 3'd0,
    REG_FINE_HEIGHT   = 3'd1,
    REG_CHANNEL_COUNT = 3'd2,
    REG_WIDE_CHANNELS = 3'd3,
    REG_SRGB_MODE     = 3'd4
  } cfg_reg_e;

  typedef logic [CODE_W-1:0] lin_tab_t [LIN_DEPTH];

  typedef logic [PORT_CH-1:0][CODE_W-1:0]  code_vec_t;
  typedef logic [PORT_CH-1:0][HSUM_W-1:0]  hsum_vec_t;
  typedef logic [PORT_CH-1:0][TOTAL_W-1:0] total_vec_t;
  typedef logic [PORT_CH-1:0][SRGB_W-1:0]  srgb_vec_t;

  typedef struct packed {
    logic h_one;
    logic row_end;
    logic image_end;
  } pair_ctl_t;

  typedef struct packed {
    logic row_end;
    logic image_end;
  } tag_t;

  // srgb code to linear light, unsigned q0.16, built at elaboration
  function automatic lin_tab_t build_lin_tab();
    lin_tab_t    tab;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] mid;
    logic [63:0] y2;
    logic [63:0] y4;
    logic [63:0] p5;
    logic [63:0] l;
    logic [63:0] v;
    for (int c = 0; c < LIN_DEPTH; c++) begin
      if (c <= 10) begin
        v = (64'd1310720 * 64'(c) + 64'd32946) / 64'd65892;
      end else begin
        x  = ((64'(c) * 64'd1000 + 64'd14025) << 30) / 64'd269025;
        x2 = (x * x) >> 30;
        lo = 64'd0;
        hi = 64'd1 << 30;
        for (int i = 0; i < 32; i++) begin
          if (lo < hi) begin
            mid = (lo + hi + 64'd1) >> 1;
            y2  = (mid * mid) >> 30;
            y4  = (y2 * y2) >> 30;
            p5  = (y4 * mid) >> 30;
            if (p5 <= x2) begin
              lo = mid;
            end else begin
              hi = mid - 64'd1;
            end
          end
        end
        l = (x2 * lo) >> 30;
        v = (l * 64'd65536 + (64'd1 << 29)) >> 30;
        if (v > 64'd65535) begin
          v = 64'd65535;
        end
      end
      tab[c] = v[CODE_W-1:0];
    end
    return tab;
  endfunction

  localparam lin_tab_t LIN_TAB = build_lin_tab();

endpackage

// ===== design/mlbd_line_ram.sv =====
// ----------------------------------------------------------------------------
// mlbd_line_ram
// line buffer of horizontal pair sums, one write and one registered read port
// ----------------------------------------------------------------------------
module mlbd_line_ram #(
  parameter int unsigned DEPTH = 2048,
  parameter int unsigned WIDTH = 68,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== design/mlbd_front.sv =====
// ----------------------------------------------------------------------------
// mlbd_front
// raster position tracking, linearisation and horizontal pair sums
// ----------------------------------------------------------------------------
`include "mip_level_box_downsampler_top_macros.svh"

module mlbd_front
  import mlbd_pkg::*;
#(
  parameter int unsigned MAX_WIDTH = 4096,
  localparam int unsigned XW  = $clog2(MAX_WIDTH),
  localparam int unsigned WW  = $clog2(MAX_WIDTH + 1),
  localparam int unsigned CXW = (MAX_WIDTH / 2 > 1) ? $clog2(MAX_WIDTH / 2) : 1
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            restart,
  input  logic            accept,
  input  logic [WW-1:0]   w_eff,
  input  logic [FH_W-1:0] h_eff,
  input  logic            wide,
  input  logic            srgb_on,
  input  code_vec_t       chan,
  output logic            emit,
  output logic            wr_en,
  output logic            rd_en,
  output logic [CXW-1:0]  cx,
  output hsum_vec_t       hs,
  output pair_ctl_t       ctl
);

  logic [XW-1:0]   x_r;
  logic [XW-1:0]   x_nxt;
  logic [FH_W-1:0] y_r;
  logic [FH_W-1:0] y_nxt;
  code_vec_t       left_r;
  code_vec_t       lin_v;
  logic            w_one;
  logic            h_one;
  logic            x_last;
  logic            y_last;
  logic            have_h;
  logic            row_end;
  logic            pair_row_last;
  logic [WW-1:0]   cw_m1;
  logic [FH_W-1:0] chh_m1;

  always_comb begin
    for (int c = 0; c < PORT_CH; c++) begin
      if (srgb_on) begin
        lin_v[c] = LIN_TAB[chan[c][SRGB_W-1:0]];
      end else if (wide) begin
        lin_v[c] = chan[c];
      end else begin
        lin_v[c] = {{(CODE_W-SRGB_W){1'b0}}, chan[c][SRGB_W-1:0]};
      end
    end
  end

  assign w_one  = (w_eff == WW'(1));
  assign h_one  = (h_eff == FH_W'(1));
  assign x_last = (WW'(x_r) == w_eff - WW'(1));
  assign y_last = (y_r == h_eff - FH_W'(1));
  assign cw_m1  = w_one ? '0 : (w_eff >> 1) - WW'(1);
  assign chh_m1 = h_one ? '0 : (h_eff >> 1) - FH_W'(1);
  assign cx     = CXW'(x_r >> 1);

  assign have_h        = w_one | x_r[0];
  assign row_end       = (WW'(cx) == cw_m1);
  assign pair_row_last = (y_r >> 1) == chh_m1;

  always_comb begin
    for (int c = 0; c < PORT_CH; c++) begin
      if (w_one) begin
        hs[c] = {lin_v[c], 1'b0};
      end else begin
        hs[c] = HSUM_W'(left_r[c]) + HSUM_W'(lin_v[c]);
      end
    end
  end

  assign emit  = have_h & (h_one | y_r[0]);
  // even row of a pair; an odd trailing row is dropped
  assign wr_en = accept & have_h & ~h_one & ~y_r[0] & ~(y_last & h_eff[0]);
  assign rd_en = accept & emit & ~h_one;

  assign ctl.h_one     = h_one;
  assign ctl.row_end   = row_end;
  assign ctl.image_end = row_end & (h_one | pair_row_last);

  always_comb begin
    x_nxt = x_r + XW'(1);
    y_nxt = y_r;
    if (x_last) begin
      x_nxt = '0;
      y_nxt = y_last ? '0 : y_r + FH_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_r    <= '0;
      y_r    <= '0;
      left_r <= '0;
    end else if (restart) begin
      x_r <= '0;
      y_r <= '0;
    end else if (accept) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      if (!x_r[0]) begin
        left_r <= lin_v;
      end
    end
  end

  `MLBD_ASSERT_NEXT(a_restart_home, clk, rst_n, restart, (x_r == '0) && (y_r == '0))
  `MLBD_ASSERT_IMPL(a_col_in_range, clk, rst_n, 1'b1, WW'(x_r) < w_eff)

endmodule

// ===== design/mlbd_srgb_search.sv =====
// ----------------------------------------------------------------------------
// mlbd_srgb_search
// pipelined bit-by-bit search of the linear-to-srgb threshold table
// ----------------------------------------------------------------------------
module mlbd_srgb_search
  import mlbd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  total_vec_t in_total,
  input  tag_t       in_tag,
  output logic       out_valid,
  input  logic       out_ready,
  output total_vec_t out_total,
  output srgb_vec_t  out_code,
  output tag_t       out_tag
);

  localparam int unsigned NS = SRGB_W;

  logic [NS-1:0] v_r;
  total_vec_t    tot_r  [NS];
  srgb_vec_t     code_r [NS];
  tag_t          tag_r  [NS];

  logic [NS:0]   stage_rdy;
  logic [NS-1:0] src_v;
  total_vec_t    src_tot  [NS];
  srgb_vec_t     src_code [NS];
  tag_t          src_tag  [NS];
  srgb_vec_t     nxt_code [NS];

  assign stage_rdy[NS] = out_ready;

  for (genvar i = 0; i < NS; i++) begin : g_stage
    localparam logic [SRGB_W-1:0] STEP_BIT = SRGB_W'(1 << (NS - 1 - i));

    if (i == 0) begin : g_head
      assign src_v[i]    = in_valid;
      assign src_tot[i]  = in_total;
      assign src_code[i] = '0;
      assign src_tag[i]  = in_tag;
    end else begin : g_body
      assign src_v[i]    = v_r[i-1];
      assign src_tot[i]  = tot_r[i-1];
      assign src_code[i] = code_r[i-1];
      assign src_tag[i]  = tag_r[i-1];
    end

    for (genvar c = 0; c < PORT_CH; c++) begin : g_chan
      logic [SRGB_W-1:0] cand;
      assign cand = src_code[i][c] | STEP_BIT;
      assign nxt_code[i][c] = ({LIN_TAB[cand], 2'b00} <= src_tot[i][c]) ? cand :
                              src_code[i][c];
    end

    assign stage_rdy[i] = ~v_r[i] | stage_rdy[i+1];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else if (stage_rdy[i]) begin
        v_r[i] <= src_v[i];
      end
    end

    always_ff @(posedge clk) begin
      if (stage_rdy[i] && src_v[i]) begin
        tot_r[i]  <= src_tot[i];
        code_r[i] <= nxt_code[i];
        tag_r[i]  <= src_tag[i];
      end
    end
  end

  assign in_ready  = stage_rdy[0];
  assign out_valid = v_r[NS-1];
  assign out_total = tot_r[NS-1];
  assign out_code  = code_r[NS-1];
  assign out_tag   = tag_r[NS-1];

endmodule

// ===== design/mip_level_box_downsampler_top.sv =====
// ----------------------------------------------------------------------------
// mip_level_box_downsampler_top
// Takes fine-level pixels in raster order, one per clock, and produces the
// next coarser mip level as 2x2 box averages, linear or through the srgb
// curve. The pixel that completes a 2x2 block yields one coarse pixel: the
// line buffer read and the vertical add land in a registered stage, then
// the pipelined srgb code search follows, one code bit per stage, which
// also carries linear results. Even rows park their horizontal pair sums
// in a line buffer of MAX_WIDTH/2 entries with one write and one read
// port, so a new pixel is taken every clock while the pipeline has room.
// The line buffer is not cleared after reset and needs no clearing pass.
// ----------------------------------------------------------------------------
`include "mip_level_box_downsampler_top_macros.svh"

module mip_level_box_downsampler_top
  import mlbd_pkg::*;
#(
  parameter int unsigned MAX_WIDTH    = 4096,
  parameter int unsigned MAX_CHANNELS = 4
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [CODE_W-1:0]     in_chan0,
  input  logic [CODE_W-1:0]     in_chan1,
  input  logic [CODE_W-1:0]     in_chan2,
  input  logic [CODE_W-1:0]     in_chan3,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [CODE_W-1:0]     out_chan0,
  output logic [CODE_W-1:0]     out_chan1,
  output logic [CODE_W-1:0]     out_chan2,
  output logic [CODE_W-1:0]     out_chan3,
  output logic                  out_row_end,
  output logic                  out_image_end,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int unsigned WW     = $clog2(MAX_WIDTH + 1);
  localparam int unsigned DEPTH  = MAX_WIDTH / 2;
  localparam int unsigned CXW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned RAM_W  = MAX_CHANNELS * HSUM_W;

  logic [FW_W-1:0]  fine_width_r;
  logic [FH_W-1:0]  fine_height_r;
  logic [NCH_W-1:0] channel_count_r;
  logic             wide_r;
  logic             srgb_r;
  logic             cfg_hit;

  logic [WW-1:0]    w_eff;
  logic [FH_W-1:0]  h_eff;
  logic [NCH_W-1:0] nch_eff;
  logic [PORT_CH-1:0] chan_mask;
  logic             srgb_on;

  code_vec_t        in_chan;
  logic             accept;
  logic             fr_emit;
  logic             ram_wr_en;
  logic             ram_rd_en;
  logic [CXW-1:0]   fr_cx;
  hsum_vec_t        fr_hs;
  pair_ctl_t        fr_ctl;

  logic [RAM_W-1:0] ram_wr_data;
  logic [RAM_W-1:0] ram_rd_data;
  hsum_vec_t        rd_hs;

  logic             s1_v_r;
  hsum_vec_t        s1_hs_r;
  pair_ctl_t        s1_ctl_r;
  logic             s1_ready;
  total_vec_t       s1_total;
  tag_t             s1_tag;

  logic             srch_in_ready;
  total_vec_t       srch_total;
  srgb_vec_t        srch_code;
  tag_t             srch_tag;
  code_vec_t        res;

  // configuration registers
  always_comb begin
    case (cfg_reg_e'(cfg_index))
      REG_FINE_WIDTH, REG_FINE_HEIGHT, REG_CHANNEL_COUNT,
      REG_WIDE_CHANNELS, REG_SRGB_MODE: cfg_hit = cfg_we;
      default:                          cfg_hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fine_width_r    <= FW_W'(1);
      fine_height_r   <= FH_W'(1);
      channel_count_r <= NCH_W'(4);
      wide_r          <= 1'b0;
      srgb_r          <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_reg_e'(cfg_index))
        REG_FINE_WIDTH:    fine_width_r    <= cfg_wdata[FW_W-1:0];
        REG_FINE_HEIGHT:   fine_height_r   <= cfg_wdata[FH_W-1:0];
        REG_CHANNEL_COUNT: channel_count_r <= cfg_wdata[NCH_W-1:0];
        REG_WIDE_CHANNELS: wide_r          <= cfg_wdata[0];
        REG_SRGB_MODE:     srgb_r          <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (fine_width_r == '0) begin
      w_eff = WW'(1);
    end else if (32'(fine_width_r) > MAX_WIDTH) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(fine_width_r);
    end
    if (channel_count_r == '0) begin
      nch_eff = NCH_W'(1);
    end else if (32'(channel_count_r) > MAX_CHANNELS) begin
      nch_eff = NCH_W'(MAX_CHANNELS);
    end else begin
      nch_eff = channel_count_r;
    end
    for (int c = 0; c < PORT_CH; c++) begin
      chan_mask[c] = 32'(nch_eff) > c;
    end
  end

  assign h_eff   = (fine_height_r == '0) ? FH_W'(1) : fine_height_r;
  assign srgb_on = srgb_r & ~wide_r;

  // input stage
  assign in_chan  = {in_chan3, in_chan2, in_chan1, in_chan0};
  assign s1_ready = ~s1_v_r | srch_in_ready;
  assign in_stall = ~s1_ready;
  assign accept   = in_valid & s1_ready;

  mlbd_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .restart (cfg_hit),
    .accept  (accept),
    .w_eff   (w_eff),
    .h_eff   (h_eff),
    .wide    (wide_r),
    .srgb_on (srgb_on),
    .chan    (in_chan),
    .emit    (fr_emit),
    .wr_en   (ram_wr_en),
    .rd_en   (ram_rd_en),
    .cx      (fr_cx),
    .hs      (fr_hs),
    .ctl     (fr_ctl)
  );

  for (genvar c = 0; c < PORT_CH; c++) begin : g_pack
    if (c < MAX_CHANNELS) begin : g_used
      assign ram_wr_data[c*HSUM_W +: HSUM_W] = fr_hs[c];
      assign rd_hs[c] = ram_rd_data[c*HSUM_W +: HSUM_W];
    end else begin : g_unused
      assign rd_hs[c] = '0;
    end
  end

  mlbd_line_ram #(
    .DEPTH (DEPTH),
    .WIDTH (RAM_W)
  ) u_line_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (fr_cx),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (fr_cx),
    .rd_data (ram_rd_data)
  );

  // vertical pair stage, line buffer data lands here
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (s1_ready) begin
      s1_v_r <= accept & fr_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && fr_emit) begin
      s1_hs_r  <= fr_hs;
      s1_ctl_r <= fr_ctl;
    end
  end

  always_comb begin
    for (int c = 0; c < PORT_CH; c++) begin
      if (s1_ctl_r.h_one) begin
        s1_total[c] = {s1_hs_r[c], 1'b0};
      end else begin
        s1_total[c] = TOTAL_W'(rd_hs[c]) + TOTAL_W'(s1_hs_r[c]);
      end
    end
  end

  assign s1_tag.row_end   = s1_ctl_r.row_end;
  assign s1_tag.image_end = s1_ctl_r.image_end;

  mlbd_srgb_search u_search (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s1_v_r),
    .in_ready  (srch_in_ready),
    .in_total  (s1_total),
    .in_tag    (s1_tag),
    .out_valid (out_valid),
    .out_ready (~out_stall),
    .out_total (srch_total),
    .out_code  (srch_code),
    .out_tag   (srch_tag)
  );

  always_comb begin
    for (int c = 0; c < PORT_CH; c++) begin
      if (!chan_mask[c]) begin
        res[c] = '0;
      end else if (srgb_on) begin
        res[c] = CODE_W'(srch_code[c]);
      end else begin
        res[c] = srch_total[c][TOTAL_W-1:2];
      end
    end
  end

  assign out_chan0     = res[0];
  assign out_chan1     = res[1];
  assign out_chan2     = res[2];
  assign out_chan3     = res[3];
  assign out_row_end   = srch_tag.row_end;
  assign out_image_end = srch_tag.image_end;

  `MLBD_ASSERT_IMPL(a_ram_one_access, clk, rst_n, ram_rd_en, !ram_wr_en)
  `MLBD_ASSERT_NEXT(a_s1_hold, clk, rst_n, s1_v_r && !s1_ready, s1_v_r && $stable(s1_hs_r))
  `MLBD_ASSERT_IMPL(a_image_end_row, clk, rst_n, out_valid && out_image_end, out_row_end)

endmodule
